@@ design/rost_pkg.sv @@
package rost_pkg;

    localparam int FRAME_MAX = 256;
    localparam int PTR_W     = $clog2(FRAME_MAX);
    localparam int LEN_W     = PTR_W + 1;

    localparam int SMP_W  = 16;
    localparam int QUO_W  = 2 * SMP_W - 1;
    localparam int SUM_W  = QUO_W + PTR_W;
    localparam int CNT_W  = $clog2(SUM_W);
    localparam int RMS_W  = 16;
    localparam int BG_W   = 32;

    localparam int FLEN_W  = 9;
    localparam int ALPHA_W = 16;
    localparam int RATIO_W = 16;
    localparam int RISE_W  = 16;
    localparam int NEED_W  = 8;
    localparam int SEG_W   = 16;
    localparam int REF_W   = 20;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_RATIO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_MIN       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_NEEDED  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_LEN    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY_LEN = 3'd6;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;
    localparam logic [Q_CNT_W-1:0] Q_FULL_CNT = Q_CNT_W'(Q_DEPTH);
    localparam logic [Q_PTR_W-1:0] Q_PTR_LAST = Q_PTR_W'(Q_DEPTH - 1);

    localparam logic [PTR_W-1:0] WP_LAST   = PTR_W'(FRAME_MAX - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SMP_W - 1);
    localparam logic [QUO_W-1:0] SQRT_BIT0 = {1'b1, {(QUO_W-1){1'b0}}};
    localparam logic [ALPHA_W:0] ALPHA_ONE = {1'b1, {ALPHA_W{1'b0}}};
    localparam logic [NEED_W-1:0] STREAK_MAX = '1;

    typedef enum logic [1:0] {
        MODE_DETECT,
        MODE_CAPTURE,
        MODE_REFRACT
    } t_mode;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_DIV,
        BS_SQRT,
        BS_MUL_OLD,
        BS_MUL_NEW,
        BS_EMA_SUM,
        BS_MUL_RATIO,
        BS_DECIDE
    } t_bstate;

    typedef struct packed {
        logic [FLEN_W-1:0]  frame_len;
        logic [ALPHA_W-1:0] ema_alpha;
        logic [RATIO_W-1:0] trigger_ratio;
        logic [RISE_W-1:0]  rise_min;
        logic [NEED_W-1:0]  frames_needed;
        logic [SEG_W-1:0]   segment_len;
        logic [REF_W-1:0]   refractory_len;
    } t_cfg;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic signed [SMP_W-1:0] delayed;
    } t_fe_item;

    typedef struct packed {
        logic signed [SMP_W-1:0] delayed_sample;
        logic                    in_segment;
        logic                    segment_last;
        logic                    trigger;
        logic [RMS_W-1:0]        frame_rms;
    } t_result;

    function automatic logic [LEN_W-1:0] eff_len(input logic [FLEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0) begin
            r = LEN_W'(1);
        end else if (int'(v) > FRAME_MAX) begin
            r = LEN_W'(FRAME_MAX);
        end else begin
            r = LEN_W'(v);
        end
        return r;
    endfunction

endpackage

@@ design/rost_ram.sv @@
module rost_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read-first: a read of the address being written returns the old word
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/rost_front.sv @@
module rost_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rost_pkg::FLEN_W-1:0]         i_frame_len,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic signed [rost_pkg::SMP_W-1:0]   i_sample,
    input  logic                                i_q_full,
    output logic                                o_q_push,
    output rost_pkg::t_fe_item                  o_q_item
);

    logic [rost_pkg::PTR_W-1:0] r_wp;
    logic                       r_filled;
    logic                       r_st_vld;
    logic signed [rost_pkg::SMP_W-1:0] r_st_smp;
    logic                       r_st_ok;

    logic [rost_pkg::LEN_W-1:0] len;
    logic [rost_pkg::PTR_W-1:0] rd;
    logic                       rd_ok;
    logic                       accept;
    logic [rost_pkg::SMP_W-1:0] rdata;

    assign len    = rost_pkg::eff_len(i_frame_len);
    assign rd     = r_wp - len[rost_pkg::PTR_W-1:0];
    // entries not yet written since reset read as zero
    assign rd_ok  = r_filled || (rd < r_wp);
    assign o_full = r_st_vld && i_q_full;
    assign accept = i_push && !o_full;

    rost_ram #(
        .WIDTH (rost_pkg::SMP_W),
        .DEPTH (rost_pkg::FRAME_MAX)
    ) u_dly (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_sample),
        .i_re    (accept),
        .i_raddr (rd),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_filled <= 1'b0;
            r_st_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_wp <= r_wp + 1'b1;
                if (r_wp == rost_pkg::WP_LAST) begin
                    r_filled <= 1'b1;
                end
                r_st_vld <= 1'b1;
            end else if (o_q_push) begin
                r_st_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_st_smp <= i_sample;
            r_st_ok  <= rd_ok;
        end
    end

    assign o_q_push        = r_st_vld && !i_q_full;
    assign o_q_item.sample = r_st_smp;
    assign o_q_item.delayed = r_st_ok ? rdata : '0;

endmodule

@@ design/rost_fifo.sv @@
module rost_fifo (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  rost_pkg::t_fe_item i_item,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_vld,
    output rost_pkg::t_fe_item o_item
);

    rost_pkg::t_fe_item           r_mem [rost_pkg::Q_DEPTH];
    logic [rost_pkg::Q_PTR_W-1:0] r_wr;
    logic [rost_pkg::Q_PTR_W-1:0] r_rd;
    logic [rost_pkg::Q_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == rost_pkg::Q_FULL_CNT);
    assign o_vld   = (r_cnt != '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_vld;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == rost_pkg::Q_PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == rost_pkg::Q_PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

@@ design/rost_back.sv @@
module rost_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rost_pkg::t_cfg     i_cfg,
    input  logic               i_q_vld,
    input  rost_pkg::t_fe_item i_q_item,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_out_vld,
    output rost_pkg::t_result  o_result
);

    rost_pkg::t_bstate r_state, n_state;
    rost_pkg::t_mode   r_mode, n_mode;

    logic [rost_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [rost_pkg::LEN_W-1:0]  r_pos, n_pos;
    logic [rost_pkg::BG_W-1:0]   r_bg, n_bg;
    logic [rost_pkg::RMS_W-1:0]  r_prev, n_prev;
    logic [rost_pkg::NEED_W-1:0] r_streak, n_streak;
    logic [rost_pkg::SEG_W-1:0]  r_seg_cnt, n_seg_cnt;
    logic [rost_pkg::REF_W-1:0]  r_ref_cnt, n_ref_cnt;
    logic                        r_out_vld, n_out_vld;

    logic [rost_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [rost_pkg::SUM_W-1:0]  r_num, n_num;
    logic [rost_pkg::LEN_W-1:0]  r_rem, n_rem;
    logic [rost_pkg::QUO_W:0]    r_root, n_root;
    logic [rost_pkg::QUO_W-1:0]  r_bit, n_bit;
    logic [48:0]                 r_p1, n_p1;
    logic [31:0]                 r_p2, n_p2;
    logic [47:0]                 r_p3, n_p3;
    logic signed [rost_pkg::SMP_W-1:0] r_dly, n_dly;
    rost_pkg::t_result           r_out, n_out;

    logic [rost_pkg::LEN_W-1:0]  len;
    logic [rost_pkg::SEG_W-1:0]  seg;
    logic [rost_pkg::NEED_W-1:0] need;
    logic                        out_free;
    logic                        take;
    logic                        is_det;
    logic signed [2*rost_pkg::SMP_W-1:0] sq;
    logic [rost_pkg::SUM_W-1:0]  sum_acc;
    logic [rost_pkg::LEN_W-1:0]  pos_inc;
    logic                        frame_end;
    logic [rost_pkg::SEG_W-1:0]  seg_inc;
    logic [rost_pkg::REF_W-1:0]  ref_dec;

    logic [rost_pkg::LEN_W:0]    rem_sh;
    logic                        div_ge;
    logic [rost_pkg::LEN_W:0]    rem_nx;
    logic [rost_pkg::QUO_W-1:0]  sq_v;
    logic [rost_pkg::QUO_W:0]    sq_t;
    logic                        sq_ge;
    logic [rost_pkg::QUO_W:0]    sq_vnx;

    logic [rost_pkg::RMS_W-1:0]  rms;
    logic [rost_pkg::BG_W-1:0]   bg_eff;
    logic [rost_pkg::ALPHA_W:0]  one_m;
    logic [49:0]                 ema;
    logic [47:0]                 rms_sh;
    logic signed [17:0]          diff;
    logic                        above;
    logic                        attack;
    logic [rost_pkg::NEED_W-1:0] streak_inc;
    logic                        trig;

    assign len      = rost_pkg::eff_len(i_cfg.frame_len);
    assign seg      = (i_cfg.segment_len == '0) ? rost_pkg::SEG_W'(1) : i_cfg.segment_len;
    assign need     = (i_cfg.frames_needed == '0) ? rost_pkg::NEED_W'(1) : i_cfg.frames_needed;
    assign out_free = !r_out_vld || i_pop;
    assign take     = (r_state == rost_pkg::BS_IDLE) && i_q_vld && out_free;
    assign is_det   = (r_mode != rost_pkg::MODE_CAPTURE) && (r_mode != rost_pkg::MODE_REFRACT);
    assign o_q_pop  = take;

    assign sq        = i_q_item.sample * i_q_item.sample;
    assign sum_acc   = r_sum + {{(rost_pkg::SUM_W-rost_pkg::QUO_W){1'b0}},
                                sq[rost_pkg::QUO_W-1:0]};
    assign pos_inc   = r_pos + 1'b1;
    assign frame_end = (pos_inc >= len);
    assign seg_inc   = r_seg_cnt + 1'b1;
    assign ref_dec   = (r_ref_cnt != '0) ? r_ref_cnt - 1'b1 : '0;

    // restoring divide, one quotient bit per cycle
    assign rem_sh = {r_rem, r_num[rost_pkg::SUM_W-1]};
    assign div_ge = (rem_sh >= {1'b0, len});
    assign rem_nx = div_ge ? rem_sh - {1'b0, len} : rem_sh;

    // bit-pair square root, one result bit per cycle
    assign sq_v   = r_num[rost_pkg::QUO_W-1:0];
    assign sq_t   = r_root + {1'b0, r_bit};
    assign sq_ge  = ({1'b0, sq_v} >= sq_t);
    assign sq_vnx = {1'b0, sq_v} - sq_t;

    assign rms    = r_root[rost_pkg::RMS_W-1:0];
    assign bg_eff = (r_bg == '0) ? {rms, 16'h0000} : r_bg;
    assign one_m  = rost_pkg::ALPHA_ONE - {1'b0, i_cfg.ema_alpha};
    assign ema    = {1'b0, r_p1} + {2'b00, r_p2, 16'h0000} + 50'd32768;

    assign rms_sh     = {4'h0, rms, 28'h0};
    assign above      = (rms_sh > r_p3);
    assign diff       = $signed({2'b00, rms}) - $signed({2'b00, r_prev});
    assign attack     = (diff > $signed({2'b00, i_cfg.rise_min}));
    assign streak_inc = (r_streak == rost_pkg::STREAK_MAX) ? r_streak : r_streak + 1'b1;
    assign trig       = above && attack && (streak_inc >= need);

    always_comb begin
        n_state = r_state;
        case (r_state)
            rost_pkg::BS_IDLE: begin
                if (take && is_det && frame_end) begin
                    n_state = rost_pkg::BS_DIV;
                end
            end
            rost_pkg::BS_DIV: begin
                if (r_cnt == rost_pkg::DIV_LAST) begin
                    n_state = rost_pkg::BS_SQRT;
                end
            end
            rost_pkg::BS_SQRT: begin
                if (r_cnt == rost_pkg::SQRT_LAST) begin
                    n_state = rost_pkg::BS_MUL_OLD;
                end
            end
            rost_pkg::BS_MUL_OLD:   n_state = rost_pkg::BS_MUL_NEW;
            rost_pkg::BS_MUL_NEW:   n_state = rost_pkg::BS_EMA_SUM;
            rost_pkg::BS_EMA_SUM:   n_state = rost_pkg::BS_MUL_RATIO;
            rost_pkg::BS_MUL_RATIO: n_state = rost_pkg::BS_DECIDE;
            rost_pkg::BS_DECIDE: begin
                if (out_free) begin
                    n_state = rost_pkg::BS_IDLE;
                end
            end
            default: n_state = rost_pkg::BS_IDLE;
        endcase
    end

    always_comb begin
        n_mode    = r_mode;
        n_sum     = r_sum;
        n_pos     = r_pos;
        n_bg      = r_bg;
        n_prev    = r_prev;
        n_streak  = r_streak;
        n_seg_cnt = r_seg_cnt;
        n_ref_cnt = r_ref_cnt;
        n_cnt     = r_cnt;
        n_num     = r_num;
        n_rem     = r_rem;
        n_root    = r_root;
        n_bit     = r_bit;
        n_p1      = r_p1;
        n_p2      = r_p2;
        n_p3      = r_p3;
        n_dly     = r_dly;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_pop;

        case (r_state)
            rost_pkg::BS_IDLE: begin
                if (take) begin
                    n_out.delayed_sample = i_q_item.delayed;
                    n_out.in_segment     = 1'b0;
                    n_out.segment_last   = 1'b0;
                    n_out.trigger        = 1'b0;
                    n_out.frame_rms      = r_prev;
                    n_out_vld            = 1'b1;
                    case (r_mode)
                        rost_pkg::MODE_CAPTURE: begin
                            n_out.in_segment = 1'b1;
                            n_seg_cnt        = seg_inc;
                            if (seg_inc >= seg) begin
                                n_out.segment_last = 1'b1;
                                n_seg_cnt          = '0;
                                if (i_cfg.refractory_len != '0) begin
                                    n_mode    = rost_pkg::MODE_REFRACT;
                                    n_ref_cnt = i_cfg.refractory_len;
                                end else begin
                                    n_mode = rost_pkg::MODE_DETECT;
                                end
                            end
                        end
                        rost_pkg::MODE_REFRACT: begin
                            n_ref_cnt = ref_dec;
                            if (ref_dec == '0) begin
                                n_mode = rost_pkg::MODE_DETECT;
                            end
                        end
                        default: begin
                            n_mode = rost_pkg::MODE_DETECT;
                            if (frame_end) begin
                                n_sum     = '0;
                                n_pos     = '0;
                                n_num     = sum_acc;
                                n_rem     = '0;
                                n_cnt     = '0;
                                n_dly     = i_q_item.delayed;
                                n_out_vld = r_out_vld && !i_pop;
                            end else begin
                                n_sum = sum_acc;
                                n_pos = pos_inc;
                            end
                        end
                    endcase
                end
            end
            rost_pkg::BS_DIV: begin
                n_rem = rem_nx[rost_pkg::LEN_W-1:0];
                n_num = {r_num[rost_pkg::SUM_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == rost_pkg::DIV_LAST) begin
                    n_cnt  = '0;
                    n_root = '0;
                    n_bit  = rost_pkg::SQRT_BIT0;
                end
            end
            rost_pkg::BS_SQRT: begin
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 1'b1;
                if (sq_ge) begin
                    n_num  = {{(rost_pkg::SUM_W-rost_pkg::QUO_W){1'b0}},
                              sq_vnx[rost_pkg::QUO_W-1:0]};
                    n_root = (r_root >> 1) + {1'b0, r_bit};
                end else begin
                    n_root = r_root >> 1;
                end
            end
            rost_pkg::BS_MUL_OLD: begin
                n_p1 = one_m * bg_eff;
            end
            rost_pkg::BS_MUL_NEW: begin
                n_p2 = i_cfg.ema_alpha * rms;
            end
            rost_pkg::BS_EMA_SUM: begin
                n_bg = ema[47:16];
            end
            rost_pkg::BS_MUL_RATIO: begin
                n_p3 = r_bg * i_cfg.trigger_ratio;
            end
            rost_pkg::BS_DECIDE: begin
                if (out_free) begin
                    n_prev = rms;
                    if (above && attack) begin
                        n_streak = streak_inc;
                        if (trig) begin
                            n_streak  = '0;
                            n_seg_cnt = '0;
                            n_mode    = rost_pkg::MODE_CAPTURE;
                        end
                    end else begin
                        n_streak = '0;
                    end
                    n_out.delayed_sample = r_dly;
                    n_out.in_segment     = 1'b0;
                    n_out.segment_last   = 1'b0;
                    n_out.trigger        = trig;
                    n_out.frame_rms      = rms;
                    n_out_vld            = 1'b1;
                end
            end
            default: begin
                n_out_vld = r_out_vld && !i_pop;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rost_pkg::BS_IDLE;
            r_mode    <= rost_pkg::MODE_DETECT;
            r_sum     <= '0;
            r_pos     <= '0;
            r_bg      <= '0;
            r_prev    <= '0;
            r_streak  <= '0;
            r_seg_cnt <= '0;
            r_ref_cnt <= '0;
            r_out_vld <= 1'b0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_sum     <= n_sum;
            r_pos     <= n_pos;
            r_bg      <= n_bg;
            r_prev    <= n_prev;
            r_streak  <= n_streak;
            r_seg_cnt <= n_seg_cnt;
            r_ref_cnt <= n_ref_cnt;
            r_out_vld <= n_out_vld;
            r_cnt     <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_bit  <= n_bit;
        r_p1   <= n_p1;
        r_p2   <= n_p2;
        r_p3   <= n_p3;
        r_dly  <= n_dly;
        r_out  <= n_out;
    end

    assign o_out_vld = r_out_vld;
    assign o_result  = r_out;

endmodule

@@ design/rms_onset_segment_trigger_unit.sv @@
// Channel   Direction  Handshake                 Payload
// request   in         push / full               i_sample
// result    out        empty / pop               o_delayed_sample, o_in_segment,
//                                                o_segment_last, o_trigger, o_frame_rms
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A request that does not close a frame is handled in the back end's idle state, after
// the front-end staging register and the queue; its result is registered. A frame-closing
// request holds the back end: the accepting step, 39 divide steps, 16 square-root steps, four
// multiply/add steps and a decision step, which waits while an earlier result is not popped.
// The delay-line RAM port and a four-entry queue let requests keep entering
// while the back end works or a result waits. Reset is synchronous; the delay line
// reads zero until written (fill tracking, no clearing pass). o_cfg_ready is always high.
module rms_onset_segment_trigger_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [rost_pkg::SMP_W-1:0]      i_sample,
    output logic                                   empty,
    input  logic                                   pop,
    output logic signed [rost_pkg::SMP_W-1:0]      o_delayed_sample,
    output logic                                   o_in_segment,
    output logic                                   o_segment_last,
    output logic                                   o_trigger,
    output logic [rost_pkg::RMS_W-1:0]             o_frame_rms,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [rost_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [rost_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    rost_pkg::t_cfg     r_cfg, n_cfg;
    rost_pkg::t_fe_item fe_item;
    rost_pkg::t_fe_item q_item;
    rost_pkg::t_result  result;
    logic               fe_push;
    logic               q_full;
    logic               q_vld;
    logic               q_pop;
    logic               out_vld;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                rost_pkg::CFG_FRAME_LEN:
                    n_cfg.frame_len = i_cfg_data[rost_pkg::FLEN_W-1:0];
                rost_pkg::CFG_EMA_ALPHA:
                    n_cfg.ema_alpha = i_cfg_data[rost_pkg::ALPHA_W-1:0];
                rost_pkg::CFG_TRIGGER_RATIO:
                    n_cfg.trigger_ratio = i_cfg_data[rost_pkg::RATIO_W-1:0];
                rost_pkg::CFG_RISE_MIN:
                    n_cfg.rise_min = i_cfg_data[rost_pkg::RISE_W-1:0];
                rost_pkg::CFG_FRAMES_NEEDED:
                    n_cfg.frames_needed = i_cfg_data[rost_pkg::NEED_W-1:0];
                rost_pkg::CFG_SEGMENT_LEN:
                    n_cfg.segment_len = i_cfg_data[rost_pkg::SEG_W-1:0];
                rost_pkg::CFG_REFRACTORY_LEN:
                    n_cfg.refractory_len = i_cfg_data[rost_pkg::REF_W-1:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_len      <= 9'd128;
            r_cfg.ema_alpha      <= 16'd655;
            r_cfg.trigger_ratio  <= 16'd12288;
            r_cfg.rise_min       <= 16'd328;
            r_cfg.frames_needed  <= 8'd2;
            r_cfg.segment_len    <= 16'd4800;
            r_cfg.refractory_len <= 20'd8000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    rost_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_frame_len (r_cfg.frame_len),
        .i_push      (push),
        .o_full      (full),
        .i_sample    (i_sample),
        .i_q_full    (q_full),
        .o_q_push    (fe_push),
        .o_q_item    (fe_item)
    );

    rost_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fe_push),
        .i_item  (fe_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    rost_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_vld   (q_vld),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_out_vld (out_vld),
        .o_result  (result)
    );

    assign empty            = !out_vld;
    assign o_delayed_sample = result.delayed_sample;
    assign o_in_segment     = result.in_segment;
    assign o_segment_last   = result.segment_last;
    assign o_trigger        = result.trigger;
    assign o_frame_rms      = result.frame_rms;

endmodule

@@ design/rost_checker.sv @@
module rost_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              empty,
    input logic                              pop,
    input logic signed [rost_pkg::SMP_W-1:0] o_delayed_sample,
    input logic                              o_in_segment,
    input logic                              o_segment_last,
    input logic                              o_trigger,
    input logic [rost_pkg::RMS_W-1:0]        o_frame_rms
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    a_last_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_segment_last) |-> o_in_segment)
        else $error("segment end outside segment");

    a_trig_not_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_trigger) |-> !o_in_segment)
        else $error("trigger during capture");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_delayed_sample)
                              && $stable(o_frame_rms)))
        else $error("stalled result changed");

endmodule

bind rms_onset_segment_trigger_unit rost_checker u_rost_checker (.*);

@@ test/onset_checker.sv @@
module onset_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    input  logic                                full,
    input  logic signed [rost_pkg::SMP_W-1:0]   i_sample,
    input  logic                                empty,
    input  logic                                pop,
    input  logic signed [rost_pkg::SMP_W-1:0]   i_delayed_sample,
    input  logic                                i_in_segment,
    input  logic                                i_segment_last,
    input  logic                                i_trigger,
    input  logic [rost_pkg::RMS_W-1:0]          i_frame_rms,
    input  logic                                i_cfg_valid,
    input  logic                                i_cfg_ready,
    input  logic [rost_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rost_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_errors,
    output int                                  o_waiting
);
    import rost_pkg::*;

    t_result due_outputs[$];
    int      results_seen;

    // detector state
    logic [SMP_W-1:0] hist [FRAME_MAX];
    int unsigned      wr_ptr;
    int unsigned      frame_fill;
    int unsigned      streak;
    logic [63:0]      energy;
    logic [BG_W-1:0]  bg_rms;
    logic [RMS_W-1:0] last_rms;
    t_mode            mode;
    logic [SEG_W-1:0] seg_cnt;
    logic [REF_W-1:0] ref_cnt;

    // register copies
    logic [FLEN_W-1:0]  c_frame_len;
    logic [ALPHA_W-1:0] c_alpha;
    logic [RATIO_W-1:0] c_ratio;
    logic [RISE_W-1:0]  c_rise;
    logic [NEED_W-1:0]  c_need;
    logic [SEG_W-1:0]   c_seg_len;
    logic [REF_W-1:0]   c_ref_len;

    initial begin
        o_errors = 0;
        o_waiting = 0;
        results_seen = 0;
    end

    function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
        logic [31:0] r;
        logic [31:0] t;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if (64'(t) * 64'(t) <= v) r = t;
        end
        return r;
    endfunction

    task automatic clear_detector();
        foreach (hist[i]) hist[i] = '0;
        wr_ptr = 0;
        frame_fill = 0;
        streak = 0;
        energy = '0;
        bg_rms = '0;
        last_rms = '0;
        mode = MODE_DETECT;
        seg_cnt = '0;
        ref_cnt = '0;
        c_frame_len = 9'd128;
        c_alpha = 16'd655;
        c_ratio = 16'd12288;
        c_rise = 16'd328;
        c_need = 8'd2;
        c_seg_len = 16'd4800;
        c_ref_len = 20'd8000;
        due_outputs.delete();
    endtask

    task automatic load_register(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_FRAME_LEN:      c_frame_len = data[FLEN_W-1:0];
            CFG_EMA_ALPHA:      c_alpha = data[ALPHA_W-1:0];
            CFG_TRIGGER_RATIO:  c_ratio = data[RATIO_W-1:0];
            CFG_RISE_MIN:       c_rise = data[RISE_W-1:0];
            CFG_FRAMES_NEEDED:  c_need = data[NEED_W-1:0];
            CFG_SEGMENT_LEN:    c_seg_len = data[SEG_W-1:0];
            CFG_REFRACTORY_LEN: c_ref_len = data[REF_W-1:0];
            default: ;
        endcase
    endtask

    task automatic advance_detector(input logic [SMP_W-1:0] raw);
        int unsigned len;
        int unsigned seg;
        int unsigned need;
        longint      sq;
        logic [31:0] rms;
        logic [63:0] mixed;
        logic        above;
        logic        attack;
        int          diff;
        int          rise_i;
        t_result     r;
        len = c_frame_len;
        if (len == 0) len = 1;
        if (len > FRAME_MAX) len = FRAME_MAX;
        seg = (c_seg_len == 0) ? 1 : c_seg_len;
        need = (c_need == 0) ? 1 : c_need;
        r.delayed_sample = hist[(wr_ptr + FRAME_MAX - len) % FRAME_MAX];
        r.in_segment = 1'b0;
        r.segment_last = 1'b0;
        r.trigger = 1'b0;
        hist[wr_ptr] = raw;
        wr_ptr = (wr_ptr + 1) % FRAME_MAX;

        if (mode == MODE_CAPTURE) begin
            r.in_segment = 1'b1;
            seg_cnt = seg_cnt + 1'b1;
            if (seg_cnt >= seg) begin
                r.segment_last = 1'b1;
                seg_cnt = '0;
                if (c_ref_len > 0) begin
                    mode = MODE_REFRACT;
                    ref_cnt = c_ref_len;
                end else begin
                    mode = MODE_DETECT;
                end
            end
        end else if (mode == MODE_REFRACT) begin
            if (ref_cnt > 0) ref_cnt = ref_cnt - 1'b1;
            if (ref_cnt == 0) mode = MODE_DETECT;
        end else begin
            mode = MODE_DETECT;
            sq = longint'($signed(raw));
            sq = sq * sq;
            energy = energy + 64'(sq);
            frame_fill++;
            if (frame_fill >= len) begin
                rms = floor_sqrt(energy / 64'(len));
                energy = '0;
                frame_fill = 0;
                if (bg_rms == 0) bg_rms = rms << 16;
                mixed = ((64'd65536 - 64'(c_alpha)) * 64'(bg_rms)
                         + 64'(c_alpha) * (64'(rms) << 16) + 64'd32768) >> 16;
                bg_rms = mixed[BG_W-1:0];
                above = (64'(rms) << 28) > 64'(bg_rms) * 64'(c_ratio);
                rise_i = c_rise;
                diff = int'(rms) - int'(last_rms);
                attack = diff > rise_i;
                last_rms = rms[RMS_W-1:0];
                if (above && attack) begin
                    if (streak < 255) streak++;
                    if (streak >= need) begin
                        r.trigger = 1'b1;
                        streak = 0;
                        seg_cnt = '0;
                        mode = MODE_CAPTURE;
                    end
                end else begin
                    streak = 0;
                end
            end
        end
        r.frame_rms = last_rms;
        due_outputs.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %0h want %0h", results_seen, what, got, want);
        o_errors++;
    endtask

    task automatic check_result();
        t_result w;
        if (due_outputs.size() == 0) begin
            report_mismatch("unexpected result", 32'd0, 32'd0);
        end else begin
            w = due_outputs.pop_front();
            if (i_delayed_sample !== w.delayed_sample)
                report_mismatch("delayed_sample", i_delayed_sample, w.delayed_sample);
            if (i_in_segment !== w.in_segment)
                report_mismatch("in_segment", i_in_segment, w.in_segment);
            if (i_segment_last !== w.segment_last)
                report_mismatch("segment_last", i_segment_last, w.segment_last);
            if (i_trigger !== w.trigger)
                report_mismatch("trigger", i_trigger, w.trigger);
            if (i_frame_rms !== w.frame_rms)
                report_mismatch("frame_rms", i_frame_rms, w.frame_rms);
        end
        results_seen++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_detector();
        end else begin
            if (i_cfg_valid && i_cfg_ready) load_register(i_cfg_index, i_cfg_data);
            if (push && !full) advance_detector(i_sample);
            if (pop && !empty) check_result();
        end
        o_waiting = due_outputs.size();
    end

endmodule

@@ test/testbench.sv @@
module testbench;
    import rost_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_ITEMS = 550;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push;
    logic                    full;
    logic signed [SMP_W-1:0] i_sample;
    logic                    empty;
    logic                    pop;
    logic signed [SMP_W-1:0] o_delayed_sample;
    logic                    o_in_segment;
    logic                    o_segment_last;
    logic                    o_trigger;
    logic [RMS_W-1:0]        o_frame_rms;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;

    int errors;
    int waiting;
    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int flen_now = 128;
    int items_sent = 0;
    int quiet_cycles;

    rms_onset_segment_trigger_unit dut (.*);

    onset_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_sample         (i_sample),
        .empty            (empty),
        .pop              (pop),
        .i_delayed_sample (o_delayed_sample),
        .i_in_segment     (o_in_segment),
        .i_segment_last   (o_segment_last),
        .i_trigger        (o_trigger),
        .i_frame_rms      (o_frame_rms),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_errors         (errors),
        .o_waiting        (waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with no request, result or register write
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("testbench: errors");
        $finish;
    end

    // result side back-pressure
    initial begin
        int stall;
        stall = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if ($urandom_range(99) < sink_stall_pct) begin
                pop <= 1'b0;
                stall = ($urandom_range(15) == 0) ? $urandom_range(20, 150)
                                                  : $urandom_range(0, 3);
            end else begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(value);
        if (idx == CFG_FRAME_LEN)
            flen_now = (value == 0) ? 1 : ((value > FRAME_MAX) ? FRAME_MAX : value);
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic end_config();
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_sample(input logic [SMP_W-1:0] v);
        int gap;
        gap = 0;
        if ($urandom_range(99) < src_idle_pct)
            gap = ($urandom_range(15) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 3);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        push <= 1'b1;
        i_sample <= v;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        push <= 1'b0;
        while (waiting != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic logic [SMP_W-1:0] draw(input int amp);
        int v;
        if (amp >= 32768) return SMP_W'($urandom);
        if (amp > 16000 && $urandom_range(31) == 0)
            return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        v = int'($urandom_range(0, 2 * amp)) - amp;
        return v[SMP_W-1:0];
    endfunction

    // quiet frames, then frames of growing level, then a sustained tail
    task automatic send_burst();
        int amp;
        int steps;
        amp = $urandom_range(0, 40);
        repeat ($urandom_range(1, 4) * flen_now) send_sample(draw(amp));
        steps = $urandom_range(1, 6);
        repeat (steps) begin
            amp = amp * $urandom_range(2, 5) + $urandom_range(20, 400);
            if (amp > 32768) amp = 32768;
            repeat (flen_now) send_sample(draw(amp));
        end
        repeat ($urandom_range(0, 2) * flen_now) send_sample(draw(amp));
    endtask

    task automatic random_phase();
        int pick;
        int stop_at;
        pick = $urandom_range(99);
        if ($urandom_range(9) < 8)
            write_reg(CFG_FRAME_LEN, (pick < 60) ? $urandom_range(1, 8) :
                                     (pick < 85) ? $urandom_range(9, 32) :
                                     (pick < 93) ? $urandom_range(33, 128) :
                                     (pick < 97) ? 0 : $urandom_range(257, 511));
        pick = $urandom_range(99);
        if ($urandom_range(1))
            write_reg(CFG_EMA_ALPHA, (pick < 15) ? 0 : (pick < 30) ? 65535 :
                                     (pick < 60) ? $urandom_range(200, 4000) :
                                     $urandom_range(0, 65535));
        pick = $urandom_range(99);
        if ($urandom_range(1))
            write_reg(CFG_TRIGGER_RATIO, (pick < 50) ? $urandom_range(4096, 8192) :
                                         (pick < 65) ? 0 :
                                         (pick < 85) ? $urandom_range(8192, 20000) :
                                         $urandom_range(0, 65535));
        pick = $urandom_range(99);
        if ($urandom_range(1))
            write_reg(CFG_RISE_MIN, (pick < 60) ? $urandom_range(0, 200) :
                                    (pick < 75) ? 0 :
                                    (pick < 90) ? $urandom_range(0, 65535) : 32768);
        if ($urandom_range(1))
            write_reg(CFG_FRAMES_NEEDED, ($urandom_range(9) < 7) ? $urandom_range(0, 3)
                                                                 : $urandom_range(0, 255));
        if ($urandom_range(1))
            write_reg(CFG_SEGMENT_LEN, ($urandom_range(3) < 3) ? $urandom_range(0, 48)
                                                               : $urandom_range(100, 300));
        pick = $urandom_range(99);
        if ($urandom_range(1))
            write_reg(CFG_REFRACTORY_LEN, (pick < 35) ? 0 :
                                          (pick < 85) ? $urandom_range(1, 48) :
                                          $urandom_range(100, 400));
        end_config();
        src_idle_pct = $urandom_range(2) * 15;
        sink_stall_pct = $urandom_range(2) * 15;
        stop_at = items_sent + $urandom_range(60, 140);
        while (items_sent < stop_at) begin
            if (flen_now <= 32 && $urandom_range(9) < 7)
                send_burst();
            else
                repeat ($urandom_range(10, 40))
                    send_sample(draw($urandom_range(1) ? 32768 : $urandom_range(0, 3000)));
        end
        drain_results();
    endtask

    initial begin
        i_rst_n = 1'b0;
        push = 1'b0;
        i_sample = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults, empty delay line
        repeat (3) send_sample(draw(32768));
        drain_results();

        // one-sample frames, single-sample segments, no refractory pause
        write_reg(CFG_FRAME_LEN, 1);
        write_reg(CFG_EMA_ALPHA, 65535);
        write_reg(CFG_TRIGGER_RATIO, 0);
        write_reg(CFG_RISE_MIN, 0);
        write_reg(CFG_FRAMES_NEEDED, 1);
        write_reg(CFG_SEGMENT_LEN, 0);
        write_reg(CFG_REFRACTORY_LEN, 0);
        end_config();
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h0002);
        send_sample(16'h7FFF);
        send_sample(16'h0000);
        drain_results();

        // zero frame length and zero frames needed
        write_reg(CFG_FRAME_LEN, 0);
        write_reg(CFG_EMA_ALPHA, 0);
        write_reg(CFG_TRIGGER_RATIO, 65535);
        write_reg(CFG_RISE_MIN, 32768);
        write_reg(CFG_FRAMES_NEEDED, 0);
        write_reg(CFG_REFRACTORY_LEN, 2);
        end_config();
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h1234);
        send_sample(16'h0000);
        send_sample(16'h7FFF);
        drain_results();

        // oversize frame length, left mid-frame by the next setting
        write_reg(CFG_FRAME_LEN, 511);
        write_reg(CFG_FRAMES_NEEDED, 255);
        write_reg(CFG_SEGMENT_LEN, 1);
        end_config();
        repeat (5) send_sample(draw(32768));
        drain_results();

        // strictly rising levels: long streak up to the largest frames needed
        write_reg(CFG_FRAME_LEN, 1);
        write_reg(CFG_EMA_ALPHA, 655);
        write_reg(CFG_TRIGGER_RATIO, 0);
        write_reg(CFG_RISE_MIN, 0);
        write_reg(CFG_SEGMENT_LEN, 3);
        write_reg(CFG_REFRACTORY_LEN, 2);
        end_config();
        src_idle_pct = 15;
        sink_stall_pct = 15;
        for (int i = 1; i <= 300; i++) send_sample(SMP_W'(i));
        drain_results();

        while (items_sent < 320 + RANDOM_ITEMS) random_phase();

        // longest frame, segment and refractory settings
        write_reg(CFG_FRAME_LEN, 256);
        write_reg(CFG_EMA_ALPHA, 655);
        write_reg(CFG_TRIGGER_RATIO, 4096);
        write_reg(CFG_RISE_MIN, 0);
        write_reg(CFG_FRAMES_NEEDED, 1);
        write_reg(CFG_SEGMENT_LEN, 65535);
        write_reg(CFG_REFRACTORY_LEN, 1048575);
        end_config();
        src_idle_pct = 0;
        sink_stall_pct = 15;
        repeat (256) send_sample(draw(20));
        repeat (296) send_sample(draw(32768));
        drain_results();
        repeat (16) @(negedge i_clk);

        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
